// ===== hw/rtl/gcpr_pkg.sv =====
package gcpr_pkg;

  // bus access kinds
  typedef enum logic [1:0] {
    OP_GP0_WRITE = 2'd0,
    OP_GP1_WRITE = 2'd1,
    OP_STAT_READ = 2'd2,
    OP_DATA_READ = 2'd3
  } op_e;

  // GP0 opcode that loads the draw-mode fields
  localparam logic [7:0] GP0_DRAW_MODE = 8'hE1;

  // GP1 opcodes
  localparam logic [7:0] GP1_RESET     = 8'h00;
  localparam logic [7:0] GP1_BUF_CLEAR = 8'h01;
  localparam logic [7:0] GP1_IRQ_ACK   = 8'h02;
  localparam logic [7:0] GP1_DISP_EN   = 8'h03;
  localparam logic [7:0] GP1_DMA_DIR   = 8'h04;
  localparam logic [7:0] GP1_DISP_AREA = 8'h05;
  localparam logic [7:0] GP1_HRANGE    = 8'h06;
  localparam logic [7:0] GP1_VRANGE    = 8'h07;
  localparam logic [7:0] GP1_DISP_MODE = 8'h08;
  localparam logic [7:0] GP1_INFO      = 8'h10;

  localparam logic [2:0]  INFO_SEL_VERSION = 3'd7;
  localparam logic [31:0] INFO_VERSION     = 32'd2;
  localparam logic [4:0]  VIDEO_RESET      = 5'h08;

  // texel depth codes
  localparam logic [1:0] TEX_15BIT = 2'd2;
  localparam logic [1:0] TEX_RSVD  = 2'd3;

  // DMA direction codes
  localparam logic [1:0] DMA_OFF  = 2'd0;
  localparam logic [1:0] DMA_FIFO = 2'd1;

  typedef struct packed {
    logic [3:0]  words_left;
    logic [7:0]  packet_code;
    logic [3:0]  page_base_x;
    logic        page_base_y;
    logic [1:0]  blend_mode;
    logic [1:0]  texel_depth;
    logic [4:0]  draw_flags;
    logic [2:0]  horiz_res;
    logic [4:0]  video_flags;
    logic        display_on;
    logic [1:0]  dma_mode;
    logic [31:0] readback;
  } state_t;

  // packet length in words, command word included; zero for unknown opcodes
  function automatic logic [3:0] packet_length(input logic [7:0] opc);
    logic [3:0] len;
    unique case (opc) inside
      8'h00, 8'h01, 8'hE1, 8'hE2, 8'hE3, 8'hE4, 8'hE5, 8'hE6: len = 4'd1;
      8'h68, 8'h6A, 8'h70, 8'h72, 8'h78, 8'h7A, 8'hC0:        len = 4'd2;
      8'h60, 8'h62, 8'hA0:                                    len = 4'd3;
      8'h20, 8'h22, 8'h80:                                    len = 4'd4;
      8'h28, 8'h2A:                                           len = 4'd5;
      8'h30, 8'h32:                                           len = 4'd6;
      8'h38, 8'h3A:                                           len = 4'd8;
      8'h2C:                                                  len = 4'd9;
      default:                                                len = 4'd0;
    endcase
    return len;
  endfunction

endpackage

// ===== hw/rtl/gpu_command_port_registers_top.sv =====
// GPU command port registers: GP0/GP1 writes, GPUSTAT and readback.
//
//   channel  | handshake             | word
//   ---------+-----------------------+-----------------------------------------
//   in       | in_valid_i/in_stall_o | op_i, data_i
//   out      | out_valid_o/out_stall_i | read_data_o, packet_done_o,
//            |                       | packet_opcode_o, unknown_opcode_o
//
// One word a cycle while the result is not stalled. A word is captured in the
// input register, then decoded against the state registers in one pass and
// written to the result register.
// Reset clears the state (interlaced set) and empties both registers.
// A stalled result holds; the input register still takes a new word while it
// is empty, and stalls only when it is full behind a stalled result.
module gpu_command_port_registers_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_data_o,
  output logic        packet_done_o,
  output logic [7:0]  packet_opcode_o,
  output logic        unknown_opcode_o
);

  // input register
  logic          in_valid_q;
  gcpr_pkg::op_e op_q;
  logic [31:0]   data_q;

  // result register
  logic          out_valid_q;
  logic [31:0]   rd_q;
  logic          done_q;
  logic [7:0]    popc_q;
  logic          unk_q;

  // decode results
  logic [31:0]   rd_d;
  logic          done_d;
  logic [7:0]    popc_d;
  logic          unk_d;

  logic          step;
  logic          in_take;

  // the held word moves on when the result slot is free or being drained
  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  gcpr_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .op_i             (op_q),
    .data_i           (data_q),
    .read_data_o      (rd_d),
    .packet_done_o    (done_d),
    .packet_opcode_o  (popc_d),
    .unknown_opcode_o (unk_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q   <= gcpr_pkg::op_e'(op_i);
      data_q <= data_i;
    end
    if (step) begin
      rd_q   <= rd_d;
      done_q <= done_d;
      popc_q <= popc_d;
      unk_q  <= unk_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = rd_q;
  assign packet_done_o    = done_q;
  assign packet_opcode_o  = popc_q;
  assign unknown_opcode_o = unk_q;

`ifndef SYNTHESIS
  a_done_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && packet_done_o |-> read_data_o == 32'd0)
    else $error("completed packet carries read data");

  a_done_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && packet_done_o |-> !unknown_opcode_o)
    else $error("completed packet flagged unknown");

  a_opcode_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !packet_done_o |-> packet_opcode_o == 8'd0)
    else $error("opcode reported without completion");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked result");

  a_step_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o)
    else $error("decoded word lost");
`endif

endmodule

// ===== hw/rtl/gcpr_status.sv =====
module gcpr_status (
  input  gcpr_pkg::state_t st_i,
  output logic [31:0]      status_o
);

  logic dma_req;

  always_comb begin
    if (st_i.dma_mode == gcpr_pkg::DMA_OFF) begin
      dma_req = 1'b0;
    end else if (st_i.dma_mode == gcpr_pkg::DMA_FIFO) begin
      dma_req = (st_i.words_left == 4'd0);
    end else begin
      dma_req = 1'b1;
    end
  end

  always_comb begin
    status_o        = '0;
    status_o[3:0]   = st_i.page_base_x;
    status_o[4]     = st_i.page_base_y;
    status_o[6:5]   = st_i.blend_mode;
    status_o[8:7]   = st_i.texel_depth;
    status_o[9]     = st_i.draw_flags[0];
    status_o[10]    = st_i.draw_flags[1];
    status_o[13]    = st_i.video_flags[4];
    status_o[15]    = st_i.draw_flags[2];
    status_o[16]    = st_i.horiz_res[2];
    status_o[18:17] = st_i.horiz_res[1:0];
    status_o[19]    = st_i.video_flags[0];
    status_o[20]    = st_i.video_flags[1];
    status_o[21]    = st_i.video_flags[2];
    status_o[22]    = st_i.video_flags[3];
    status_o[23]    = ~st_i.display_on;  // set means display disabled
    status_o[25]    = dma_req;
    status_o[28:26] = 3'b111;
    status_o[30:29] = st_i.dma_mode;
  end

endmodule

// ===== hw/rtl/gcpr_core.sv =====
module gcpr_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  gcpr_pkg::op_e  op_i,
  input  logic [31:0]    data_i,
  output logic [31:0]    read_data_o,
  output logic           packet_done_o,
  output logic [7:0]     packet_opcode_o,
  output logic           unknown_opcode_o
);

  gcpr_pkg::state_t st_q, st_d;
  logic [31:0] status;
  logic [7:0]  opc;
  logic [3:0]  len;
  logic [3:0]  wl_new;
  logic        il;

  assign opc = data_i[31:24];
  assign len = gcpr_pkg::packet_length(opc);
  assign il  = data_i[5];

  gcpr_status u_status (
    .st_i     (st_q),
    .status_o (status)
  );

  always_comb begin
    st_d             = st_q;
    read_data_o      = '0;
    packet_done_o    = 1'b0;
    packet_opcode_o  = '0;
    unknown_opcode_o = 1'b0;
    wl_new           = st_q.words_left - 4'd1;
    unique case (op_i)
      gcpr_pkg::OP_GP0_WRITE: begin
        if (st_q.words_left == 4'd0 && len == 4'd0) begin
          unknown_opcode_o = 1'b1;
        end else begin
          if (st_q.words_left == 4'd0) begin
            wl_new            = len - 4'd1;
            st_d.packet_code  = opc;
          end
          st_d.words_left = wl_new;
          if (wl_new == 4'd0) begin
            packet_done_o   = 1'b1;
            packet_opcode_o = st_d.packet_code;
            if (st_d.packet_code == gcpr_pkg::GP0_DRAW_MODE) begin
              st_d.page_base_x = data_i[3:0];
              st_d.page_base_y = data_i[4];
              st_d.blend_mode  = data_i[6:5];
              st_d.texel_depth = (data_i[8:7] == gcpr_pkg::TEX_RSVD) ?
                                 gcpr_pkg::TEX_15BIT : data_i[8:7];
              st_d.draw_flags  = data_i[13:9];
            end
          end
        end
      end
      gcpr_pkg::OP_GP1_WRITE: begin
        unique case (opc) inside
          gcpr_pkg::GP1_RESET: begin
            st_d.page_base_x = '0;
            st_d.page_base_y = 1'b0;
            st_d.blend_mode  = '0;
            st_d.texel_depth = '0;
            st_d.draw_flags  = '0;
            st_d.readback    = '0;
            st_d.dma_mode    = gcpr_pkg::DMA_OFF;
            st_d.display_on  = 1'b0;
            st_d.horiz_res   = '0;
            st_d.video_flags = gcpr_pkg::VIDEO_RESET | {st_q.video_flags[4], 4'b0000};
            st_d.words_left  = '0;
          end
          gcpr_pkg::GP1_BUF_CLEAR: st_d.words_left = '0;
          gcpr_pkg::GP1_IRQ_ACK, gcpr_pkg::GP1_DISP_AREA,
          gcpr_pkg::GP1_HRANGE, gcpr_pkg::GP1_VRANGE: begin
            st_d = st_q;
          end
          gcpr_pkg::GP1_DISP_EN: st_d.display_on = ~data_i[0];
          gcpr_pkg::GP1_DMA_DIR: st_d.dma_mode = data_i[1:0];
          gcpr_pkg::GP1_DISP_MODE: begin
            st_d.horiz_res   = {data_i[6], data_i[1:0]};
            st_d.video_flags = {il, il, data_i[4], data_i[3], data_i[2]};
          end
          gcpr_pkg::GP1_INFO: begin
            if (data_i[2:0] == gcpr_pkg::INFO_SEL_VERSION) begin
              st_d.readback = gcpr_pkg::INFO_VERSION;
            end
          end
          default: unknown_opcode_o = 1'b1;
        endcase
      end
      gcpr_pkg::OP_STAT_READ: read_data_o = status;
      gcpr_pkg::OP_DATA_READ: read_data_o = st_q.readback;
      default: read_data_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{video_flags: gcpr_pkg::VIDEO_RESET, default: '0};
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

endmodule
